// ===== hw/rtl/csvft_pkg.sv =====
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 64;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned COL_W   = 6;
    localparam int unsigned ROW_W   = 32;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 2;

    localparam logic [APB_AW-1:0] ADDR_DELIM = 2'd0;

    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'h0A;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h2C;

    typedef enum logic [2:0] {
        ST_TOKEN,
        ST_QOPEN,
        ST_QCLOSE,
        ST_QUOTED,
        ST_DELIM,
        ST_NEWLINE
    } t_pstate;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA,
        KIND_FIELD,
        KIND_RECORD
    } t_kind;

    typedef struct packed {
        t_pstate state;
        logic    emit;
        t_kind   kind;
    } t_step_res;

endpackage

// ===== hw/rtl/csvft_if.sv =====
// ----------------------------------------------------------------------------
// csvft_in_if / csvft_out_if
// Valid/ready channels for raw stream bytes and tokenizer results.
// ----------------------------------------------------------------------------
interface csvft_in_if;
    import csvft_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface csvft_out_if;
    import csvft_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [COL_W-1:0]  column_index;
    logic [ROW_W-1:0]  row_index;

    modport source (output valid, output kind, output data_byte,
                    output column_index, output row_index, input ready);
    modport sink   (input valid, input kind, input data_byte,
                    input column_index, input row_index, output ready);
endinterface

// ===== hw/rtl/csv_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Byte-serial CSV tokenizer with quoted fields, column and row tracking.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   i_in      in   valid/ready   in_byte
//   o_out     out  valid/ready   kind, data_byte, column_index, row_index
//   apb       in   psel/penable  delimiter register at address 0
//
// One byte per cycle while i_in.ready is high; a byte is parsed in the cycle
// it is accepted and its result sits in the output register the next cycle;
// the parse state and counters update in that same cycle. i_in.ready is high
// while the output register is empty or being drained. Reset is synchronous;
// a NUL byte halts the parser until reset, later bytes are taken and dropped.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit #(
    parameter int unsigned MAX_COLUMNS = csvft_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    csvft_in_if.sink                      i_in,
    csvft_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csvft_pkg::APB_AW-1:0]  paddr,
    input  logic [csvft_pkg::APB_DW-1:0]  pwdata,
    output logic [csvft_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import csvft_pkg::*;

    localparam int unsigned CW = $clog2(MAX_COLUMNS);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);

    logic [BYTE_W-1:0] r_delim;
    t_pstate           r_state;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_halted;

    logic              r_out_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_data;
    logic [COL_W-1:0]  r_col_out;
    logic [ROW_W-1:0]  r_row_out;

    t_step_res         step;
    logic              in_acc;
    logic              live;
    logic              load;
    logic [CW+COL_W-1:0] col_ext;

    csvft_step u_step (
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .i_delim (r_delim),
        .o_res   (step)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign live       = in_acc && !r_halted && (i_in.in_byte != CH_NUL);
    assign load       = live && step.emit;
    assign col_ext    = {{COL_W{1'b0}}, r_col};

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_DELIM) begin
            prdata = {{(APB_DW-BYTE_W){1'b0}}, r_delim};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_DELIM) begin
            r_delim <= pwdata[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_TOKEN;
            r_col    <= '0;
            r_row    <= '0;
            r_halted <= 1'b0;
        end else if (in_acc && !r_halted) begin
            if (i_in.in_byte == CH_NUL) begin
                r_halted <= 1'b1;
            end else begin
                r_state <= step.state;
                case (step.state)
                    ST_DELIM: begin
                        if (r_col != COL_LAST) begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                    ST_NEWLINE: begin
                        r_col <= '0;
                        if (r_row != {ROW_W{1'b1}}) begin
                            r_row <= r_row + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= step.kind;
            r_data    <= i_in.in_byte;
            r_col_out <= col_ext[COL_W-1:0];
            r_row_out <= r_row;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.data_byte    = r_data;
    assign o_out.column_index = r_col_out;
    assign o_out.row_index    = r_row_out;

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && o_out.ready |=> !o_out.valid)
        else $error("result produced while halted");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column counter past its limit");

    a_record_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && step.kind == KIND_RECORD |=> r_col == '0)
        else $error("column counter not cleared at record end");

endmodule

// ===== hw/rtl/csvft_step.sv =====
// ----------------------------------------------------------------------------
// csvft_step
// Byte classification and parse state transition for one stream byte.
// ----------------------------------------------------------------------------
module csvft_step (
    input  csvft_pkg::t_pstate        i_state,
    input  logic [7:0]                i_byte,
    input  logic [7:0]                i_delim,
    output csvft_pkg::t_step_res      o_res
);
    import csvft_pkg::*;

    logic    is_quote;
    logic    is_nl;
    logic    is_sep;
    logic    in_quotes;
    t_pstate n_state;

    assign is_quote  = (i_byte == CH_QUOTE);
    assign is_nl     = (i_byte == CH_NEWLINE);
    assign is_sep    = (i_byte == i_delim);
    assign in_quotes = (i_state inside {ST_QOPEN, ST_QUOTED});

    // next state
    always_comb begin
        if (is_quote) begin
            case (i_state)
                ST_QOPEN, ST_QUOTED: n_state = ST_QCLOSE;
                ST_QCLOSE:           n_state = ST_QUOTED;
                default:             n_state = ST_QOPEN;
            endcase
        end else if (in_quotes) begin
            n_state = ST_QUOTED;
        end else if (is_nl) begin
            n_state = ST_NEWLINE;
        end else if (is_sep) begin
            n_state = ST_DELIM;
        end else begin
            n_state = ST_TOKEN;
        end
    end

    // outputs
    always_comb begin
        o_res.state = n_state;
        case (n_state)
            ST_TOKEN, ST_QUOTED: begin
                o_res.emit = 1'b1;
                o_res.kind = KIND_DATA;
            end
            ST_DELIM: begin
                o_res.emit = 1'b1;
                o_res.kind = KIND_FIELD;
            end
            ST_NEWLINE: begin
                o_res.emit = 1'b1;
                o_res.kind = KIND_RECORD;
            end
            default: begin
                o_res.emit = 1'b0;
                o_res.kind = KIND_DATA;
            end
        endcase
    end

endmodule
